// ----- design/sxfb_pkg.sv -----
// sxfb_pkg: shared types, constants and the table builder for the sprite xor framebuffer
// used by every module of the block; depends on nothing
`default_nettype none

package sxfb_pkg;

    // default screen size
    localparam int unsigned SCREEN_WIDTH  = 64;
    localparam int unsigned SCREEN_HEIGHT = 32;

    // largest supported screen; sizes the command and result fields
    localparam int unsigned MAX_COLS = 64;
    localparam int unsigned ROW_BITS = 6;

    // leftmost pixel of a pattern byte
    localparam logic [7:0] PATTERN_TOP = 8'h80;

    // operation codes
    localparam logic [1:0] OP_CLEAR = 2'd0;
    localparam logic [1:0] OP_DRAW  = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;
    localparam logic [1:0] OP_NONE  = 2'd3;

    // input transaction
    typedef struct packed {
        logic [1:0] opcode;
        logic [7:0] x_pos;
        logic [7:0] y_pos;
        logic [3:0] row_index;
        logic [7:0] sprite_bits;
        logic       last_row;
    } t_in;

    // result transaction
    typedef struct packed {
        logic                collision;
        logic                final_row;
        logic                changed;
        logic [MAX_COLS-1:0] row_data;
    } t_out;

    // classified command passed from front to back
    typedef struct packed {
        logic [1:0]          op;
        logic [ROW_BITS-1:0] row;
        logic [MAX_COLS-1:0] mask;
        logic                clr_acc;
        logic                last;
        logic                changed;
    } t_cmd;

    // byte value reduced modulo a screen dimension
    typedef logic [ROW_BITS-1:0] t_mod_tab [256];

    // builds the residue table by a wrapping count
    function automatic t_mod_tab build_mod_tab(int unsigned m);
        t_mod_tab    tab;
        int unsigned r;
        r = 0;
        for (int unsigned i = 0; i < 256; i++) begin
            tab[i] = ROW_BITS'(r);
            if (r == m - 1) begin
                r = 0;
            end else begin
                r = r + 1;
            end
        end
        return tab;
    endfunction

endpackage

`default_nettype wire

// ----- design/sxfb_front.sv -----
// sxfb_front: accepts input transactions, works out the target row and column mask
// depends on sxfb_pkg
`default_nettype none

module sxfb_front #(
    parameter int unsigned WIDTH  = sxfb_pkg::SCREEN_WIDTH,
    parameter int unsigned HEIGHT = sxfb_pkg::SCREEN_HEIGHT
) (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_in_valid,
    output logic             o_in_ready,
    input  sxfb_pkg::t_in    i_in_data,
    input  wire              i_q_full,
    output logic             o_push,
    output sxfb_pkg::t_cmd   o_cmd
);

    localparam sxfb_pkg::t_mod_tab X_TAB = sxfb_pkg::build_mod_tab(WIDTH);
    localparam sxfb_pkg::t_mod_tab Y_TAB = sxfb_pkg::build_mod_tab(HEIGHT);
    localparam logic [sxfb_pkg::ROW_BITS:0] W_LIM = (sxfb_pkg::ROW_BITS+1)'(WIDTH);
    localparam logic [sxfb_pkg::ROW_BITS:0] H_LIM = (sxfb_pkg::ROW_BITS+1)'(HEIGHT);

    logic [sxfb_pkg::ROW_BITS-1:0] y_mod;
    logic [sxfb_pkg::ROW_BITS-1:0] x_mod;
    logic [sxfb_pkg::ROW_BITS:0]   row_sum;
    logic [sxfb_pkg::ROW_BITS:0]   row_s1;
    logic [sxfb_pkg::ROW_BITS:0]   row_s2;
    logic [sxfb_pkg::MAX_COLS-1:0] col_mask;
    logic                          is_draw;

    // accept whenever the queue has room
    assign o_in_ready = !i_q_full;
    assign o_push     = i_in_valid && !i_q_full;

    assign y_mod   = Y_TAB[i_in_data.y_pos];
    assign x_mod   = X_TAB[i_in_data.x_pos];
    assign is_draw = (i_in_data.opcode == sxfb_pkg::OP_DRAW);

    // sprite row wraps; sum stays below three screen heights
    always_comb begin
        row_sum = {1'b0, y_mod} + (sxfb_pkg::ROW_BITS+1)'(i_in_data.row_index);
        row_s1  = (row_sum >= H_LIM) ? row_sum - H_LIM : row_sum;
        row_s2  = (row_s1 >= H_LIM) ? row_s1 - H_LIM : row_s1;
    end

    // one pixel lane per pattern bit, each column wrapping once at most
    always_comb begin
        logic [sxfb_pkg::ROW_BITS:0] col;
        col_mask = '0;
        for (int k = 0; k < 8; k++) begin
            col = {1'b0, x_mod} + (sxfb_pkg::ROW_BITS+1)'(k);
            if (col >= W_LIM) begin
                col = col - W_LIM;
            end
            if ((i_in_data.sprite_bits & (sxfb_pkg::PATTERN_TOP >> k)) != 8'd0) begin
                col_mask[col[sxfb_pkg::ROW_BITS-1:0]] = 1'b1;
            end
        end
    end

    // build the command
    always_comb begin
        o_cmd         = '0;
        o_cmd.op      = i_in_data.opcode;
        o_cmd.row     = is_draw ? row_s2[sxfb_pkg::ROW_BITS-1:0] : y_mod;
        o_cmd.mask    = is_draw ? col_mask : '0;
        o_cmd.clr_acc = is_draw && (i_in_data.row_index == 4'd0);
        o_cmd.last    = is_draw && i_in_data.last_row;
        o_cmd.changed = is_draw && (i_in_data.sprite_bits != 8'd0);
    end

    // a pushed draw never targets a row past the screen
    a_row_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |-> ((sxfb_pkg::ROW_BITS+1)'(o_cmd.row) < H_LIM))
        else $error("command row outside screen");

endmodule

`default_nettype wire

// ----- design/sxfb_queue.sv -----
// sxfb_queue: two-entry command queue between front and back
// depends on sxfb_pkg
`default_nettype none

module sxfb_queue (
    input  wire            i_clk,
    input  wire            i_rst_n,
    input  wire            i_push,
    input  sxfb_pkg::t_cmd i_data,
    output logic           o_full,
    input  wire            i_pop,
    output logic           o_valid,
    output sxfb_pkg::t_cmd o_data
);

    sxfb_pkg::t_cmd r_ent [2];
    logic           r_wr_ptr;
    logic           r_rd_ptr;
    logic [1:0]     r_count;
    logic           do_push;
    logic           do_pop;

    assign o_full  = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_data  = r_ent[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    // entry storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_ent[r_wr_ptr] <= i_data;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (do_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            r_count <= r_count + 2'(do_push) - 2'(do_pop);
        end
    end

    // a push alone grows the count by one
    a_push_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (do_push && !do_pop) |=> (r_count == $past(r_count) + 2'd1))
        else $error("queue count did not follow push");

endmodule

`default_nettype wire

// ----- design/sxfb_back.sv -----
// sxfb_back: executes commands against the frame ram, keeps collision state
// and holds the result register; depends on sxfb_pkg
`default_nettype none

module sxfb_back #(
    parameter int unsigned WIDTH  = sxfb_pkg::SCREEN_WIDTH,
    parameter int unsigned HEIGHT = sxfb_pkg::SCREEN_HEIGHT
) (
    input  wire            i_clk,
    input  wire            i_rst_n,
    input  wire            i_q_valid,
    input  sxfb_pkg::t_cmd i_q_data,
    output logic           o_pop,
    output logic           o_out_valid,
    input  wire            i_out_ready,
    output sxfb_pkg::t_out o_out_data
);

    localparam int unsigned AW = $clog2(HEIGHT);

    localparam logic ST_FETCH = 1'b0;
    localparam logic ST_EXEC  = 1'b1;

    logic [WIDTH-1:0] r_frame [HEIGHT];
    logic [HEIGHT-1:0] r_row_vld;
    logic [WIDTH-1:0] r_rd_data;
    logic             r_rd_vld;
    logic             r_state;
    sxfb_pkg::t_cmd   r_cmd;
    logic             r_acc;
    logic             r_out_vld;
    sxfb_pkg::t_out   r_out;

    logic             out_free;
    logic             exec;
    logic [AW-1:0]    rd_addr;
    logic [AW-1:0]    wr_addr;
    logic [WIDTH-1:0] old_row;
    logic [WIDTH-1:0] mask_w;
    logic             hit;
    logic             n_acc;
    sxfb_pkg::t_out   n_out;

    assign out_free = !r_out_vld || i_out_ready;
    assign o_pop    = (r_state == ST_FETCH) && i_q_valid;
    assign exec     = (r_state == ST_EXEC) && out_free;
    assign rd_addr  = i_q_data.row[AW-1:0];
    assign wr_addr  = r_cmd.row[AW-1:0];
    assign old_row  = r_rd_vld ? r_rd_data : '0;
    assign mask_w   = r_cmd.mask[WIDTH-1:0];
    assign hit      = ((old_row & mask_w) != '0);

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

    // collision accumulator and result assembly
    always_comb begin
        n_acc = r_acc;
        n_out = '0;
        unique case (r_cmd.op)
            sxfb_pkg::OP_DRAW: begin
                n_acc = (r_acc && !r_cmd.clr_acc) || hit;
            end
            sxfb_pkg::OP_READ: begin
                n_out.row_data = sxfb_pkg::MAX_COLS'(old_row);
            end
            default: begin
            end
        endcase
        n_out.collision = n_acc;
        n_out.final_row = r_cmd.last;
        n_out.changed   = r_cmd.changed;
    end

    // frame ram: registered read on fetch, write back on execute
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_rd_data <= r_frame[rd_addr];
            r_rd_vld  <= r_row_vld[rd_addr];
            r_cmd     <= i_q_data;
        end
        if (exec && r_cmd.op == sxfb_pkg::OP_DRAW) begin
            r_frame[wr_addr] <= old_row ^ mask_w;
        end
        if (exec) begin
            r_out <= n_out;
        end
    end

    // row valid bits stand in for a dark screen
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_vld <= '0;
        end else if (exec && r_cmd.op == sxfb_pkg::OP_CLEAR) begin
            r_row_vld <= '0;
        end else if (exec && r_cmd.op == sxfb_pkg::OP_DRAW) begin
            r_row_vld[wr_addr] <= 1'b1;
        end
    end

    // sequencer, collision state and result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_FETCH;
            r_acc     <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            unique case (r_state)
                ST_FETCH: begin
                    if (i_q_valid) begin
                        r_state <= ST_EXEC;
                    end
                end
                ST_EXEC: begin
                    if (out_free) begin
                        r_state <= ST_FETCH;
                    end
                end
                default: begin
                    r_state <= ST_FETCH;
                end
            endcase
            if (exec) begin
                r_acc     <= n_acc;
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // a stalled execute holds its command
    a_exec_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EXEC && !out_free) |=> (r_state == ST_EXEC && $stable(r_cmd)))
        else $error("execute left while result register busy");

    // a finished clear leaves the whole screen dark
    a_clear_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (exec && r_cmd.op == sxfb_pkg::OP_CLEAR) |=> (r_row_vld == '0))
        else $error("clear left rows marked");

    // draw results never carry row contents
    a_draw_no_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && (r_out.final_row || r_out.changed)) |-> (r_out.row_data == '0))
        else $error("draw result carries row data");

endmodule

`default_nettype wire

// ----- design/sprite_xor_framebuffer.sv -----
// sprite_xor_framebuffer: top level of the monochrome sprite framebuffer
// depends on sxfb_pkg, sxfb_front, sxfb_queue, sxfb_back
//
// Usage: one command per input transaction on the in channel (valid/ready):
// clear screen, xor-draw one 8-pixel sprite row with wrap, or read one row.
// Every accepted transaction yields exactly one result transaction on the
// out channel (valid/ready) carrying collision, final_row, changed and
// row_data, in order.
// Path: an accepted transaction is queued, fetched (frame ram read) and
// executed into the result register. The back end takes one transaction
// at a time, set by the read-then-write of its single frame ram port.
// The front end classifies commands into a 2-entry queue, so up to two
// further transactions are taken while the back end or receiver is busy.
// Reset: synchronous, active low. Row valid bits clear at once, so the
// screen reads dark right away; there is no clearing pass.
// A stalled receiver holds the result register; the back end then waits
// and the queue fills before in ready drops.
`default_nettype none

module sprite_xor_framebuffer #(
    parameter int unsigned SCREEN_WIDTH  = sxfb_pkg::SCREEN_WIDTH,
    parameter int unsigned SCREEN_HEIGHT = sxfb_pkg::SCREEN_HEIGHT
) (
    input  wire            i_clk,
    input  wire            i_rst_n,
    input  wire            i_in_valid,
    output logic           o_in_ready,
    input  sxfb_pkg::t_in  i_in_data,
    output logic           o_out_valid,
    input  wire            i_out_ready,
    output sxfb_pkg::t_out o_out_data
);

    logic           q_full;
    logic           q_push;
    logic           q_pop;
    logic           q_valid;
    sxfb_pkg::t_cmd push_cmd;
    sxfb_pkg::t_cmd pop_cmd;

    // front end: accept and classify
    sxfb_front #(
        .WIDTH  (SCREEN_WIDTH),
        .HEIGHT (SCREEN_HEIGHT)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .i_q_full   (q_full),
        .o_push     (q_push),
        .o_cmd      (push_cmd)
    );

    // command queue
    sxfb_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (push_cmd),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_data  (pop_cmd)
    );

    // back end: frame ram and results
    sxfb_back #(
        .WIDTH  (SCREEN_WIDTH),
        .HEIGHT (SCREEN_HEIGHT)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_q_data    (pop_cmd),
        .o_pop       (q_pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

`default_nettype wire
